// ===== hdl/pcb_pkg.sv =====
// shared types, register codes and saturation helpers for the pid core
package pcb_pkg;

  localparam int MAG_W = 33;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DVD_W = MAG_W + 16;
  localparam int CFG_AW = 5;

  localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] CFG_FILTER_TAU = 3'd3;
  localparam logic [2:0] CFG_OUT_MIN    = 3'd4;
  localparam logic [2:0] CFG_OUT_MAX    = 3'd5;
  localparam logic [2:0] CFG_INTEG_MIN  = 3'd6;
  localparam logic [2:0] CFG_INTEG_MAX  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } pcb_state_t;

  function automatic logic [31:0] sat_mag(input logic neg, input logic [PROD_W-1:0] m);
    logic [31:0] r;
    if (neg) begin
      if ((m[PROD_W-1:32] != '0) || (m[31] && (m[30:0] != '0))) begin
        r = 32'h8000_0000;
      end else begin
        r = ~m[31:0] + 32'd1;
      end
    end else begin
      if (m[PROD_W-1:31] != '0) begin
        r = 32'h7fff_ffff;
      end else begin
        r = m[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] abs34(input logic signed [33:0] v);
    logic [33:0] n;
    n = 34'(-v);
    return v[33] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

// ===== hdl/pcb_mul.sv =====
// bit-serial shift-add multiplier for unsigned magnitudes
module pcb_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcb_pkg::MAG_W-1:0]   a,
  input  logic [pcb_pkg::MAG_W-1:0]   b,
  output logic                        busy,
  output logic [pcb_pkg::PROD_W-1:0]  prod
);
  import pcb_pkg::*;

  logic [MAG_W-1:0] a_r, hi_r, lo_r;
  logic [MAG_W-1:0] hi_nxt, lo_nxt;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [MAG_W:0]   sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign hi_nxt = sum[MAG_W:1];
  assign lo_nxt = {sum[0], lo_r[MAG_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(MAG_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = {hi_r, lo_r};
endmodule

// ===== hdl/pcb_div.sv =====
// restoring divider, one quotient bit per cycle
module pcb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pcb_pkg::DVD_W-1:0]  dvd,
  input  logic [pcb_pkg::MAG_W-1:0]  den,
  output logic                       busy,
  output logic [pcb_pkg::DVD_W-1:0]  quo
);
  import pcb_pkg::*;

  logic [MAG_W-1:0] rem_r, den_r, rem_nxt;
  logic [DVD_W-1:0] q_r;
  logic [MAG_W:0]   sh, diff;
  logic             ge;
  logic [5:0]       cnt_r;
  logic             busy_r;

  assign sh      = {rem_r, q_r[DVD_W-1]};
  assign ge      = sh >= {1'b0, den_r};
  assign diff    = sh - {1'b0, den_r};
  assign rem_nxt = ge ? diff[MAG_W-1:0] : sh[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dvd;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

// ===== hdl/pid_controller_bandlimited_core.sv =====
// pid controller top level: apb registers, sequencer and serial arithmetic
//
//  channel | ports                                  | direction
//  in      | in_valid in_stall in_target in_sensed   | transfer into the core
//          | in_step_time                           |
//  out     | out_valid out_stall out_drive           | transfer out of the core
//  cfg     | cfg_psel cfg_penable cfg_pwrite ...     | apb register access
//
// each item runs four parallel bit-serial multiplies, then the serial divide
// that runs beside the integral multiply. reset clears the configuration,
// the accumulators, the state and the output valid flag.
// a new item is taken once the previous one reaches the output register;
// a stalled output holds the core before it writes the next result.
module pid_controller_bandlimited_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_target,
  input  logic signed [31:0]             in_sensed,
  input  logic [30:0]                    in_step_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_drive,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pcb_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import pcb_pkg::*;

  pcb_state_t state_r, state_nxt;

  logic signed [31:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [30:0]        filter_tau_r;
  logic signed [31:0] out_min_r, out_max_r, integ_min_r, integ_max_r;

  logic signed [31:0] integ_acc_r, deriv_acc_r, last_error_r, last_sensed_r;
  logic signed [31:0] out_drive_r;
  logic               out_valid_r;

  logic signed [31:0] error_r, sensed_r;
  logic signed [33:0] esum_r;
  logic [MAG_W-1:0]   den_r;
  logic               nprop_r, nk_r, nt1_r, nt2_r;
  logic signed [31:0] prop_r, k_r, t1_r, t2_r, incr_r, deriv_r;
  logic               nnum_r;

  logic [2:0] cfg_idx;
  logic       cfg_wr;

  logic               accept, mul_start, prep_start, mul_busy, div_busy;
  logic signed [33:0] diff_ts, dm, ts, num;
  logic signed [31:0] error;
  logic [MAG_W-1:0]   a0, b0, a1, b1, a2, b2, a3, b3, den;
  logic [PROD_W-1:0]  p0, p1, p2, p3;
  logic [DVD_W-1:0]   quo;
  logic [MAG_W-1:0]   num_mag;
  logic               busy0, busy1, busy2, busy3;
  logic signed [31:0] integ_new, drive;

  // configuration
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      filter_tau_r <= '0;
      out_min_r    <= '0;
      out_max_r    <= '0;
      integ_min_r  <= '0;
      integ_max_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_PROP_GAIN:  prop_gain_r  <= cfg_pwdata;
        CFG_INTEG_GAIN: integ_gain_r <= cfg_pwdata;
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_pwdata;
        CFG_FILTER_TAU: filter_tau_r <= cfg_pwdata[30:0];
        CFG_OUT_MIN:    out_min_r    <= cfg_pwdata;
        CFG_OUT_MAX:    out_max_r    <= cfg_pwdata;
        CFG_INTEG_MIN:  integ_min_r  <= cfg_pwdata;
        CFG_INTEG_MAX:  integ_max_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_PROP_GAIN:  cfg_prdata = prop_gain_r;
      CFG_INTEG_GAIN: cfg_prdata = integ_gain_r;
      CFG_DERIV_GAIN: cfg_prdata = deriv_gain_r;
      CFG_FILTER_TAU: cfg_prdata = {1'b0, filter_tau_r};
      CFG_OUT_MIN:    cfg_prdata = out_min_r;
      CFG_OUT_MAX:    cfg_prdata = out_max_r;
      CFG_INTEG_MIN:  cfg_prdata = integ_min_r;
      CFG_INTEG_MAX:  cfg_prdata = integ_max_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // operands at the input transfer
  assign diff_ts = 34'(in_target) - 34'(in_sensed);
  assign error   = sat34(diff_ts);
  assign dm      = 34'(in_sensed) - 34'(last_sensed_r);
  assign ts      = $signed({2'b00, filter_tau_r, 1'b0}) - $signed({3'b000, in_step_time});
  assign den     = {1'b0, filter_tau_r, 1'b0} + {2'b00, in_step_time};

  assign a0 = abs34(34'(prop_gain_r));
  assign b0 = abs34(34'(error));
  assign a1 = prep_start ? abs34(34'(k_r)) : abs34(34'(integ_gain_r));
  assign b1 = prep_start ? abs34(esum_r) : {2'b00, in_step_time};
  assign a2 = abs34(34'(deriv_gain_r));
  assign b2 = abs34(dm);
  assign a3 = abs34(ts);
  assign b3 = abs34(34'(deriv_acc_r));

  pcb_mul u_mul0 (.clk, .rst_n, .start(mul_start), .a(a0), .b(b0), .busy(busy0), .prod(p0));
  pcb_mul u_mul1 (.clk, .rst_n, .start(mul_start | prep_start), .a(a1), .b(b1),
                  .busy(busy1), .prod(p1));
  pcb_mul u_mul2 (.clk, .rst_n, .start(mul_start), .a(a2), .b(b2), .busy(busy2), .prod(p2));
  pcb_mul u_mul3 (.clk, .rst_n, .start(mul_start), .a(a3), .b(b3), .busy(busy3), .prod(p3));

  assign mul_busy = busy0 | busy1 | busy2 | busy3;

  assign num     = 34'(t1_r) + 34'(t2_r);
  assign num_mag = abs34(num);

  pcb_div u_div (
    .clk, .rst_n,
    .start(prep_start),
    .dvd({num_mag, 16'd0}),
    .den(den_r),
    .busy(div_busy),
    .quo(quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  if (!mul_busy) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (!mul_busy && !div_busy) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    accept     = (state_r == ST_IDLE) && in_valid;
    mul_start  = accept;
    prep_start = (state_r == ST_PREP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      error_r  <= error;
      sensed_r <= in_sensed;
      esum_r   <= 34'(error) + 34'(last_error_r);
      den_r    <= den;
      nprop_r  <= prop_gain_r[31] ^ error[31];
      nk_r     <= integ_gain_r[31];
      nt1_r    <= ~(deriv_gain_r[31] ^ dm[33]);
      nt2_r    <= ts[33] ^ deriv_acc_r[31];
    end
    if (state_r == ST_MUL && !mul_busy) begin
      prop_r <= sat_mag(nprop_r, PROD_W'(p0[PROD_W-1:16]));
      k_r    <= sat_mag(nk_r, PROD_W'(p1[PROD_W-1:16]));
      t1_r   <= sat_mag(nt1_r, PROD_W'(p2[PROD_W-1:15]));
      t2_r   <= sat_mag(nt2_r, PROD_W'(p3[PROD_W-1:16]));
    end
    if (prep_start) begin
      nnum_r <= num[33];
    end
    if (state_r == ST_DIV && !mul_busy && !div_busy) begin
      incr_r  <= sat_mag(k_r[31] ^ esum_r[33], PROD_W'(p1[PROD_W-1:17]));
      deriv_r <= (den_r == '0) ? 32'sd0 : sat_mag(nnum_r, PROD_W'(quo));
    end
  end

  assign integ_new = clamp32(sat34(34'(integ_acc_r) + 34'(incr_r)), integ_min_r, integ_max_r);
  assign drive     = clamp32(sat34(34'(prop_r) + 34'(integ_acc_r) + 34'(deriv_acc_r)),
                             out_min_r, out_max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r   <= '0;
      deriv_acc_r   <= '0;
      last_error_r  <= '0;
      last_sensed_r <= '0;
    end else if (state_r == ST_UPD) begin
      integ_acc_r   <= integ_new;
      deriv_acc_r   <= deriv_r;
      last_error_r  <= error_r;
      last_sensed_r <= sensed_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_drive_r <= drive;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
endmodule

// ===== test/pid_controller_bandlimited_core_tb.sv =====
// testbench for the pid core: directed and random transfers checked against a predictor
`timescale 1ns / 100ps

module pid_controller_bandlimited_core_tb;
  import pcb_pkg::*;

  class drive_scoreboard;
    longint kp, ki, kd, tau, omin, omax, imin, imax;
    longint integ, deriv, prev_err, prev_meas;
    logic signed [31:0] pending[$];
    int errors;

    function new();
      kp = 0; ki = 0; kd = 0; tau = 0; omin = 0; omax = 0; imin = 0; imax = 0;
      integ = 0; deriv = 0; prev_err = 0; prev_meas = 0; errors = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint mulsh(longint a, longint b, int sh);
      logic [63:0] ua, ub, m;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      m = (ua * ub) >> sh;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_PROP_GAIN:  kp = longint'(signed'(v));
        CFG_INTEG_GAIN: ki = longint'(signed'(v));
        CFG_DERIV_GAIN: kd = longint'(signed'(v));
        CFG_FILTER_TAU: tau = longint'({33'd0, v[30:0]});
        CFG_OUT_MIN:    omin = longint'(signed'(v));
        CFG_OUT_MAX:    omax = longint'(signed'(v));
        CFG_INTEG_MIN:  imin = longint'(signed'(v));
        default:        imax = longint'(signed'(v));
      endcase
    endfunction

    function void note_sample(logic signed [31:0] tgt, logic signed [31:0] meas,
                              logic [30:0] dt);
      longint t, m, st, e, p, k, inc, dm, t1, t2, num, den, d;
      t = tgt; m = meas; st = longint'({33'd0, dt});
      e = sat(t - m);
      p = sat(mulsh(kp, e, 16));
      k = sat(mulsh(ki, st, 16));
      inc = sat(mulsh(k, e + prev_err, 17));
      integ = lim(sat(integ + inc), imin, imax);
      dm = m - prev_meas;
      t1 = sat(-mulsh(kd, dm, 15));
      t2 = sat(mulsh(2 * tau - st, deriv, 16));
      num = t1 + t2;
      den = 2 * tau + st;
      deriv = (den == 0) ? 0 : sat((num * 65536) / den);
      d = lim(sat(p + integ + deriv), omin, omax);
      prev_err = e;
      prev_meas = m;
      pending.push_back(d[31:0]);
    endfunction

    function void check_drive(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending.size() == 0) begin
        report_err("drive transfer with nothing expected", got, 0);
        return;
      end
      want = pending.pop_front();
      if (got !== want) report_err("drive", got, want);
    endfunction

    function void report_err(string what, logic [31:0] got, logic [31:0] want);
      $display("error: %s got %h want %h", what, got, want);
      errors++;
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] in_target = 0, in_sensed = 0, out_drive;
  logic [30:0] in_step_time = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;

  int send_gap = 0, recv_gap = 0;
  drive_scoreboard sb = new();

  pid_controller_bandlimited_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_drive(out_drive);
    if (rst_n) out_stall <= ($urandom_range(99) < recv_gap);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= CFG_AW'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, v);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [31:0] tgt, logic signed [31:0] meas,
                             logic [30:0] dt);
    while ($urandom_range(99) < send_gap) @(posedge clk);
    in_valid <= 1; in_target <= tgt; in_sensed <= meas; in_step_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(tgt, meas, dt);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_all(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h3_0000);
      3: return -$urandom_range(32'h3_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rnd_dt();
    case ($urandom_range(5))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'd1;
      default: return 31'($urandom_range(31'h2_0000));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] v[8];
    v[0] = rnd_word(); v[1] = rnd_word(); v[2] = rnd_word();
    v[3] = $urandom_range(3) == 0 ? 32'h7fff_ffff : $urandom_range(32'h4_0000);
    v[4] = -$urandom_range(32'h7fff_ffff); v[5] = $urandom_range(32'h7fff_ffff);
    v[6] = -$urandom_range(32'h7fff_ffff); v[7] = $urandom_range(32'h7fff_ffff);
    if ($urandom_range(5) == 0) begin
      v[4] = 32'h8000_0000; v[5] = 32'h7fff_ffff;
    end
    if ($urandom_range(7) == 0) v[6] = 32'h0010_0000;
    load_all(v);
    for (int i = 0; i < n; i++) begin
      send_sample(rnd_word(), rnd_word(), rnd_dt());
      if (i == n / 2 && $urandom_range(3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    logic [31:0] v[8];
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, crossed limits, zero divisor
    send_sample(32'sh0001_0000, 0, 31'h1_0000);
    drain();
    v = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_0000,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    load_all(v);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff);
    send_sample(0, 0, 31'd0);
    send_sample(32'sh0002_0000, 32'sh0001_0000, 31'h0000_0666);
    send_sample(32'sh0002_0000, 32'sh0001_8000, 31'h0000_0666);
    drain();
    v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h0001_0000, 32'hffff_0000, 32'h0010_0000, 32'hfff0_0000};
    load_all(v);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff);
    send_sample(32'sh0000_1000, 32'sh0000_0800, 31'd1);
    send_sample(0, 32'sh7fff_ffff, 31'd0);
    send_sample(32'sh5555_5555, 32'shaaaa_aaaa, 31'h2aaa_aaaa);
    send_sample(32'shaaaa_aaaa, 32'sh5555_5555, 31'h5555_5555);
    drain();
    v = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    load_all(v);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 31'd1);
    send_sample(-1, 1, 31'h1_0000);
    drain();

    send_gap = 8; recv_gap = 80;
    for (int p = 0; p < 6; p++) random_phase(100);
    send_gap = 80; recv_gap = 8;
    for (int p = 0; p < 6; p++) random_phase(100);
    send_gap = 0; recv_gap = 0;
    for (int p = 0; p < 6; p++) random_phase(100);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("pid_controller_bandlimited_core: match");
    end else begin
      $display("pid_controller_bandlimited_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("pid_controller_bandlimited_core: mismatch");
    $finish;
  end
endmodule
